// ===== hdl/pgp_pkg.sv =====
// Shared package of the polar go-to-pose controller: codes, widths,
// reset values, CORDIC arctangent table and control structs.
// No dependencies.
package pgp_pkg;

	// Default parameter values
	localparam int CORDIC_ITERATIONS_DEF = 16;
	localparam int POSITION_BITS_DEF     = 24;
	localparam int ANGLE_BITS_DEF        = 16;

	// Fixed field widths
	localparam int HEADING_W  = 16;
	localparam int GAIN_W     = 16;
	localparam int DIST_W     = 24;
	localparam int TOL_W      = 15;
	localparam int LIN_W      = 24;
	localparam int ANG_W      = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int MODE_W     = 2;

	// Output saturation limits
	localparam int ANG_MAX = 524287;
	localparam int ANG_MIN = -524288;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RHO     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ALPHA   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BETA    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE_DIST  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADING_TOL  = 3'd4;

	// Configuration reset values
	localparam logic [GAIN_W-1:0] GAIN_RHO_RST     = 16'd2048;
	localparam logic [GAIN_W-1:0] GAIN_ALPHA_RST   = 16'd6144;
	localparam logic [GAIN_W-1:0] GAIN_BETA_RST    = 16'd2458;
	localparam logic [DIST_W-1:0] ARRIVE_DIST_RST  = 24'd3277;
	localparam logic [TOL_W-1:0]  HEADING_TOL_RST  = 15'd939;

	// Item opcodes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_GOAL = 1'b1;

	// Controller modes
	localparam logic [MODE_W-1:0] MODE_MOVE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ROTATE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REACHED = 2'd2;

	// 1/K of the CORDIC in Q0.16
	localparam logic [GAIN_W-1:0] KINV_Q16 = 16'd39797;

	// Arctangent table, 2^32 units per turn
	localparam int ATAN_IW = 5;

	function automatic logic [31:0] atan_lut(input logic [ATAN_IW-1:0] idx);
		logic [31:0] r;
		unique case (idx)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10680862;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// CORDIC status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} cor_st_t;

	// Multiply-accumulate command
	typedef struct packed {
		logic en;      // issue a product
		logic init;    // start a new sum from the rounding constant
		logic rnd_hi;  // rounding constant 2^23, else 2^11
		logic neg;     // subtract the product
		logic hi;      // product is the upper partial, shift up
	} mac_ctl_t;

endpackage

// ===== hdl/pgp_if.sv =====
// Handshake channels of the go-to-pose controller: input items and
// result items, each with valid, ready and payload. Depends on pgp_pkg.
interface pgp_in_if #(
	parameter int POSITION_BITS = pgp_pkg::POSITION_BITS_DEF
) ();
	import pgp_pkg::*;

	logic                           valid;
	logic                           ready;
	logic                           opcode;
	logic signed [POSITION_BITS-1:0] pos_x;
	logic signed [POSITION_BITS-1:0] pos_y;
	logic signed [HEADING_W-1:0]     heading;
	logic                           pose_valid;

	modport source (output valid, opcode, pos_x, pos_y, heading, pose_valid, input ready);
	modport sink (input valid, opcode, pos_x, pos_y, heading, pose_valid, output ready);
endinterface

interface pgp_out_if ();
	import pgp_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [LIN_W-1:0]        linear_velocity;
	logic signed [ANG_W-1:0] angular_rate;

	modport source (output valid, linear_velocity, angular_rate, input ready);
	modport sink (input valid, linear_velocity, angular_rate, output ready);
endinterface

// ===== hdl/polar_go_to_pose_controller.sv =====
// Polar go-to-pose controller top level: sequencer, pose and twist state,
// angle arithmetic and output register. Depends on pgp_pkg, pgp_if,
// pgp_cordic and pgp_mac.
//
// A goal item (opcode 1) stores the goal pose, sets Move and gives no
// result. A control tick occupies the block through the iterative CORDIC,
// one micro-rotation per cycle, and the passes through the single shared
// multiply-accumulate unit: distance scaling, then, only when Move issues
// a new twist, the two gain sums. in_item.ready is high only between
// items. A tick with a valid pose yields one result item, held in an
// output register so the next item can be taken while it waits; a tick
// whose pose is invalid runs the mode machine on the stored pose and gives
// no result. Angles are binary with 2^ANGLE_BITS per turn; speeds saturate
// to the output widths.
module polar_go_to_pose_controller #(
	parameter int CORDIC_ITERATIONS = pgp_pkg::CORDIC_ITERATIONS_DEF,
	parameter int POSITION_BITS     = pgp_pkg::POSITION_BITS_DEF,
	parameter int ANGLE_BITS        = pgp_pkg::ANGLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	pgp_in_if.sink                          in_item,
	pgp_out_if.source                       out_item,
	input  logic                            cfg_we,
	input  logic [pgp_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [pgp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pgp_pkg::*;

	localparam int PW = POSITION_BITS;
	localparam int A  = ANGLE_BITS;
	localparam int CW = PW + 12;
	localparam int HS = (CW + 1) / 2;
	localparam int RW = CW - 8;
	localparam int MA = (HS + 1 > A) ? HS + 1 : A;
	localparam int AW = CW + 18;
	localparam int SW = AW - 12;
	localparam int TW = (A > TOL_W) ? A : TOL_W;
	localparam int DW = (RW > DIST_W) ? RW : DIST_W;
	localparam int UP = (A >= HEADING_W) ? A - HEADING_W : 0;
	localparam int DN = (A < HEADING_W) ? HEADING_W - A : 0;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIFF = 4'd1;
	localparam logic [3:0] S_CORD = 4'd2;
	localparam logic [3:0] S_RHO0 = 4'd3;
	localparam logic [3:0] S_RHO1 = 4'd4;
	localparam logic [3:0] S_RHO2 = 4'd5;
	localparam logic [3:0] S_DEC  = 4'd6;
	localparam logic [3:0] S_V0   = 4'd7;
	localparam logic [3:0] S_V1   = 4'd8;
	localparam logic [3:0] S_W0   = 4'd9;
	localparam logic [3:0] S_W1   = 4'd10;
	localparam logic [3:0] S_W2   = 4'd11;
	localparam logic [3:0] S_W3   = 4'd12;
	localparam logic [3:0] S_OUT  = 4'd13;

	logic [3:0] state_q;

	// configuration
	logic [GAIN_W-1:0] gain_rho_q, gain_alpha_q, gain_beta_q;
	logic [DIST_W-1:0] arrive_q;
	logic [TOL_W-1:0]  tol_q;

	// controller state
	logic [MODE_W-1:0]        mode_q;
	logic signed [PW-1:0]     goal_x_q, goal_y_q, robot_x_q, robot_y_q;
	logic [HEADING_W-1:0]     goal_head_q, robot_head_q;
	logic [LIN_W-1:0]         held_lin_q;
	logic signed [ANG_W-1:0]  held_ang_q;
	logic                     valid_q;

	// working registers
	logic signed [A-1:0] theta_q, alpha_q, beta_q;
	logic [A-1:0]        atheta_q;
	logic [RW-1:0]       rho_q;

	// output register
	logic                    out_valid_q;
	logic [LIN_W-1:0]        out_lin_q;
	logic signed [ANG_W-1:0] out_ang_q;

	logic in_acc, out_load;

	// shared units
	logic                cor_start;
	logic signed [PW:0]  dx, dy;
	cor_st_t             cor_st;
	logic [CW-1:0]       mag;
	logic [A-1:0]        bearing;
	mac_ctl_t            mac_ctl;
	logic signed [MA-1:0] mac_a;
	logic [GAIN_W-1:0]   mac_b;
	logic signed [AW-1:0] acc;

	// heading field to angle units
	function automatic logic [A-1:0] to_angle(input logic [HEADING_W-1:0] h);
		logic signed [47:0] e;
		e = 48'($signed(h));
		e = (e <<< UP) >>> DN;
		return e[A-1:0];
	endfunction

	// angle arithmetic, all wrapping modulo one turn
	logic [A-1:0] gh, rh, theta_w, alpha_w, beta_w, atheta_w;
	assign gh       = to_angle(goal_head_q);
	assign rh       = to_angle(robot_head_q);
	assign theta_w  = gh - rh;
	assign alpha_w  = bearing - rh;
	assign beta_w   = theta_w - alpha_w;
	assign atheta_w = theta_w[A-1] ? (~theta_w + 1'b1) : theta_w;

	// distance from the accumulator and the reach tests
	logic [RW-1:0] rho_now;
	logic          near, aligned;
	assign rho_now = acc[RW+23:24];
	assign near    = DW'(rho_now) < DW'(arrive_q);
	assign aligned = TW'(atheta_q) < TW'(tol_q);

	// shared saturator for the turn rate, plus the linear-speed clamp
	logic signed [SW-1:0]    sat_src;
	logic signed [ANG_W-1:0] sat_ang;
	logic [SW-1:0]           v_src;
	logic [LIN_W-1:0]        sat_lin;
	always_comb begin
		sat_src = (state_q == S_DEC) ? SW'(theta_q) : acc[AW-1:12];
		if (sat_src > SW'(ANG_MAX)) begin
			sat_ang = ANG_W'(ANG_MAX);
		end else if (sat_src < SW'(ANG_MIN)) begin
			sat_ang = ANG_W'(ANG_MIN);
		end else begin
			sat_ang = sat_src[ANG_W-1:0];
		end
		v_src   = acc[AW-1:12];
		sat_lin = (|v_src[SW-1:LIN_W]) ? '1 : v_src[LIN_W-1:0];
	end

	// offsets to the goal
	assign dx = {goal_x_q[PW-1], goal_x_q} - {robot_x_q[PW-1], robot_x_q};
	assign dy = {goal_y_q[PW-1], goal_y_q} - {robot_y_q[PW-1], robot_y_q};
	assign cor_start = (state_q == S_DIFF);

	pgp_cordic #(
		.ITER (CORDIC_ITERATIONS),
		.PW   (PW),
		.AB   (A),
		.CW   (CW)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.dx      (dx),
		.dy      (dy),
		.st      (cor_st),
		.mag     (mag),
		.bearing (bearing)
	);

	// multiply-accumulate commands per step
	always_comb begin
		mac_ctl = '0;
		mac_a   = '0;
		mac_b   = '0;
		unique case (state_q)
			S_RHO0: begin
				mac_ctl = '{en: 1'b1, init: 1'b1, rnd_hi: 1'b1, neg: 1'b0, hi: 1'b0};
				mac_a   = $signed(MA'(mag[HS-1:0]));
				mac_b   = KINV_Q16;
			end
			S_RHO1: begin
				mac_ctl = '{en: 1'b1, init: 1'b0, rnd_hi: 1'b0, neg: 1'b0, hi: 1'b1};
				mac_a   = $signed(MA'(mag[CW-1:HS]));
				mac_b   = KINV_Q16;
			end
			S_V0: begin
				mac_ctl = '{en: 1'b1, init: 1'b1, rnd_hi: 1'b0, neg: 1'b0, hi: 1'b0};
				mac_a   = $signed(MA'(rho_q[HS-1:0]));
				mac_b   = gain_rho_q;
			end
			S_V1: begin
				mac_ctl = '{en: 1'b1, init: 1'b0, rnd_hi: 1'b0, neg: 1'b0, hi: 1'b1};
				mac_a   = $signed(MA'(rho_q[RW-1:HS]));
				mac_b   = gain_rho_q;
			end
			S_W0: begin
				mac_ctl = '{en: 1'b1, init: 1'b1, rnd_hi: 1'b0, neg: 1'b0, hi: 1'b0};
				mac_a   = MA'(alpha_q);
				mac_b   = gain_alpha_q;
			end
			S_W1: begin
				mac_ctl = '{en: 1'b1, init: 1'b0, rnd_hi: 1'b0, neg: 1'b1, hi: 1'b0};
				mac_a   = MA'(beta_q);
				mac_b   = gain_beta_q;
			end
			default: begin
				mac_ctl = '0;
			end
		endcase
	end

	pgp_mac #(
		.MA (MA),
		.AW (AW),
		.HS (HS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (acc)
	);

	// handshakes
	assign in_item.ready = (state_q == S_IDLE);
	assign in_acc        = in_item.valid && in_item.ready;
	assign out_load      = (state_q == S_OUT) && valid_q &&
	                       (!out_valid_q || out_item.ready);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_rho_q   <= GAIN_RHO_RST;
			gain_alpha_q <= GAIN_ALPHA_RST;
			gain_beta_q  <= GAIN_BETA_RST;
			arrive_q     <= ARRIVE_DIST_RST;
			tol_q        <= HEADING_TOL_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_GAIN_RHO:    gain_rho_q   <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_ALPHA:  gain_alpha_q <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_BETA:   gain_beta_q  <= cfg_data[GAIN_W-1:0];
				CFG_ARRIVE_DIST: arrive_q     <= cfg_data[DIST_W-1:0];
				CFG_HEADING_TOL: tol_q        <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, pose and twist state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= MODE_REACHED;
			goal_x_q     <= '0;
			goal_y_q     <= '0;
			goal_head_q  <= '0;
			robot_x_q    <= '0;
			robot_y_q    <= '0;
			robot_head_q <= '0;
			held_lin_q   <= '0;
			held_ang_q   <= '0;
			valid_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_item.opcode == OP_GOAL) begin
							goal_x_q    <= in_item.pos_x;
							goal_y_q    <= in_item.pos_y;
							goal_head_q <= in_item.heading;
							mode_q      <= MODE_MOVE;
						end else begin
							valid_q <= in_item.pose_valid;
							if (in_item.pose_valid) begin
								robot_x_q    <= in_item.pos_x;
								robot_y_q    <= in_item.pos_y;
								robot_head_q <= in_item.heading;
							end
							state_q <= S_DIFF;
						end
					end
				end
				S_DIFF: state_q <= S_CORD;
				S_CORD: begin
					if (cor_st.done) begin
						state_q <= S_RHO0;
					end
				end
				S_RHO0: state_q <= S_RHO1;
				S_RHO1: state_q <= S_RHO2;
				S_RHO2: state_q <= S_DEC;
				S_DEC: begin
					state_q <= S_OUT;
					if (mode_q == MODE_MOVE) begin
						if (near) begin
							mode_q <= aligned ? MODE_REACHED : MODE_ROTATE;
						end else begin
							state_q <= S_V0;
						end
					end else if (mode_q == MODE_ROTATE) begin
						if (aligned) begin
							mode_q <= MODE_REACHED;
						end else begin
							held_lin_q <= '0;
							held_ang_q <= sat_ang;
						end
					end else begin
						held_lin_q <= '0;
						held_ang_q <= '0;
					end
				end
				S_V0: state_q <= S_V1;
				S_V1: state_q <= S_W0;
				S_W0: state_q <= S_W1;
				S_W1: begin
					held_lin_q <= sat_lin;
					state_q    <= S_W2;
				end
				S_W2: state_q <= S_W3;
				S_W3: begin
					held_ang_q <= sat_ang;
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (!valid_q || out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// angle and distance working registers
	always_ff @(posedge clk) begin
		if (state_q == S_RHO0) begin
			theta_q  <= theta_w;
			alpha_q  <= alpha_w;
			beta_q   <= beta_w;
			atheta_q <= atheta_w;
		end
		if (state_q == S_DEC) begin
			rho_q <= rho_now;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_item.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_lin_q <= held_lin_q;
			out_ang_q <= held_ang_q;
		end
	end

	assign out_item.valid           = out_valid_q;
	assign out_item.linear_velocity = out_lin_q;
	assign out_item.angular_rate    = out_ang_q;

	// checks
	a_goal_sets_move: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_item.opcode == OP_GOAL) |=> (mode_q == MODE_MOVE))
		else $error("goal item did not set Move");

	a_cordic_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cor_st.done |-> (state_q == S_CORD))
		else $error("CORDIC finished outside its wait step");

	a_reached_zero_twist: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEC && mode_q == MODE_REACHED) |=>
		(held_lin_q == '0 && held_ang_q == '0))
		else $error("twist not cleared in Reached");

	a_no_result_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !valid_q) |=> !$rose(out_valid_q))
		else $error("result given for an invalid pose");

endmodule

// ===== hdl/pgp_cordic.sv =====
// Iterative vectoring CORDIC: one micro-rotation per cycle through a
// shared barrel shifter and adders. Gives magnitude and rounded bearing.
// Depends on pgp_pkg.
module pgp_cordic #(
	parameter int ITER = pgp_pkg::CORDIC_ITERATIONS_DEF,
	parameter int PW   = pgp_pkg::POSITION_BITS_DEF,
	parameter int AB   = pgp_pkg::ANGLE_BITS_DEF,
	parameter int CW   = PW + 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [PW:0]    dx,
	input  logic signed [PW:0]    dy,
	output pgp_pkg::cor_st_t      st,
	output logic [CW-1:0]         mag,
	output logic [AB-1:0]         bearing
);
	import pgp_pkg::*;

	localparam int CNTW = $clog2(ITER);

	logic signed [CW-1:0] x_q, y_q;
	logic [31:0]          z_q;
	logic [CNTW-1:0]      cnt_q;
	logic                 busy_q, done_q, zero_q;

	logic signed [CW-1:0] xs, ys, x_sh, y_sh;
	logic [31:0]          atan_i, z_rnd;

	// offsets scaled by 256
	assign xs = CW'(dx) <<< 8;
	assign ys = CW'(dy) <<< 8;

	// shared shifter for the current iteration
	assign x_sh   = x_q >>> cnt_q;
	assign y_sh   = y_q >>> cnt_q;
	assign atan_i = atan_lut(ATAN_IW'(cnt_q));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNTW'(ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// datapath: quarter-turn pre-rotation, then micro-rotations
	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (dx == '0) && (dy == '0);
			if (xs[CW-1]) begin
				if (!ys[CW-1]) begin
					x_q <= ys;
					y_q <= -xs;
					z_q <= 32'h4000_0000;
				end else begin
					x_q <= -ys;
					y_q <= xs;
					z_q <= 32'hC000_0000;
				end
			end else begin
				x_q <= xs;
				y_q <= ys;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + atan_i;
			end else begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - atan_i;
			end
		end
	end

	// bearing rounded half up to the angle width
	assign z_rnd   = z_q + (32'd1 << (31 - AB));
	assign bearing = zero_q ? '0 : z_rnd[31 -: AB];
	assign mag     = x_q;
	assign st      = '{busy: busy_q, done: done_q};

endmodule

// ===== hdl/pgp_mac.sv =====
// Shared multiply-accumulate unit: registered product, then a rounding
// accumulator that adds, subtracts or shifts up partial products.
// Depends on pgp_pkg.
module pgp_mac #(
	parameter int MA = 25,
	parameter int AW = 54,
	parameter int HS = 18
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pgp_pkg::mac_ctl_t        ctl,
	input  logic signed [MA-1:0]     a,
	input  logic [pgp_pkg::GAIN_W-1:0] b,
	output logic signed [AW-1:0]     acc
);
	import pgp_pkg::*;

	localparam int PWD = MA + GAIN_W + 1;

	mac_ctl_t              ctl_s1;
	logic signed [PWD-1:0] p_s1;
	logic signed [AW-1:0]  acc_q, term, term_sh, base;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			p_s1 <= a * $signed({1'b0, b});
		end
	end

	// accumulate stage
	always_comb begin
		term    = AW'(p_s1);
		term_sh = ctl_s1.hi ? (term <<< HS) : term;
		if (ctl_s1.init) begin
			base = ctl_s1.rnd_hi ? (AW'(1) <<< 23) : (AW'(1) <<< 11);
		end else begin
			base = acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.en) begin
			acc_q <= ctl_s1.neg ? (base - term_sh) : (base + term_sh);
		end
	end

	assign acc = acc_q;

endmodule
